// File: sv/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion that also holds while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/lcdws_pkg.sv
// Types and constants for the character LCD write sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcdws_pkg;

   localparam int unsigned StepWidth = 3;

   localparam logic [1:0] CSR_DISPLAY_READY = 2'd0;
   localparam logic [1:0] CSR_EIGHT_BIT_BUS = 2'd1;
   localparam logic [1:0] CSR_UPPER_LANE    = 2'd2;
   localparam logic [1:0] CSR_STEP_HOLD     = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [1:0] STATUS_BAD_POS   = 2'd2;

   localparam logic [7:0] CURSOR_CMD   = 8'h80;
   localparam logic [15:0] HOLD_RESET  = 16'd50;

   localparam logic [StepWidth-1:0] LAST_STEP_EIGHT = 3'd3;
   localparam logic [StepWidth-1:0] LAST_STEP_FOUR  = 3'd6;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
      logic [3:0] row;
      logic [4:0] column;
   } req_item_type;

   typedef struct packed {
      logic        reg_select;
      logic        read_write;
      logic        enable_pin;
      logic [7:0]  data_port;
      logic [15:0] hold_time_us;
      logic [1:0]  status;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic        display_ready;
      logic        eight_bit_bus;
      logic        upper_nibble_lane;
      logic [15:0] step_hold_us;
   } csr_type;

   typedef struct packed {
      logic [1:0] status;
      logic       reg_select;
      logic [7:0] cmd_byte;
   } cmd_type;

   function automatic logic [7:0] row_offset(input logic [1:0] row);
      case (row)
         2'd0:    row_offset = 8'h00;
         2'd1:    row_offset = 8'h40;
         2'd2:    row_offset = 8'h10;
         default: row_offset = 8'h50;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: sv/char_lcd_write_sequencer.sv
// A request is written into the command queue; its first snapshot then goes to the result register once it is free.
// Throughput: one snapshot per cycle from the sequencer's result register while results are popped;
// 4 snapshots per transaction in eight-bit mode, 7 in four-bit mode, 1 on a rejection.
// A two-entry command queue lets requests be taken while snapshots drain.
// Synchronous active-high reset clears queue, sequencer, port latch and strobe, and sets the settings to defaults.
`default_nettype none
module char_lcd_write_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  lcdws_pkg::req_item_type req_item,
   output logic                    empty,
   input  logic                    pop,
   output lcdws_pkg::rsp_item_type rsp_item,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata
);
   import lcdws_pkg::*;

   csr_type csr_ff;
   cmd_type front_cmd, head_cmd;
   logic    head_valid, cmd_done, req_accept;

   assign req_accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.display_ready     <= 1'b0;
         csr_ff.eight_bit_bus     <= 1'b0;
         csr_ff.upper_nibble_lane <= 1'b1;
         csr_ff.step_hold_us      <= HOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DISPLAY_READY: csr_ff.display_ready     <= csr_wdata[0];
            CSR_EIGHT_BIT_BUS: csr_ff.eight_bit_bus     <= csr_wdata[0];
            CSR_UPPER_LANE:    csr_ff.upper_nibble_lane <= csr_wdata[0];
            CSR_STEP_HOLD:     csr_ff.step_hold_us      <= csr_wdata;
            default:           ;
         endcase
      end
   end

   lcdws_front u_front (
      .req_item (req_item),
      .csr      (csr_ff),
      .cmd      (front_cmd)
   );

   lcdws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_accept),
      .wr_cmd   (front_cmd),
      .full     (full),
      .rd_en    (cmd_done),
      .rd_valid (head_valid),
      .rd_cmd   (head_cmd)
   );

   lcdws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_done  (cmd_done),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

// File: sv/lcdws_front.sv
// Front end: classifies a request into a write command or a rejection.
// Depends on lcdws_pkg.
`default_nettype none
module lcdws_front (
   input  lcdws_pkg::req_item_type req_item,
   input  lcdws_pkg::csr_type      csr,
   output lcdws_pkg::cmd_type      cmd
);
   import lcdws_pkg::*;

   logic bad_pos;
   logic [7:0] cursor_byte;

   assign bad_pos     = (req_item.row > 4'd3) || (req_item.column > 5'd15);
   assign cursor_byte = CURSOR_CMD |
                        ({3'd0, req_item.column} + row_offset(req_item.row[1:0]));

   always_comb begin
      cmd.status     = STATUS_OK;
      cmd.reg_select = 1'b0;
      cmd.cmd_byte   = req_item.data_byte;
      if (!csr.display_ready) begin
         cmd.status = STATUS_NOT_READY;
      end else if (req_item.req_type[1]) begin
         cmd.cmd_byte = cursor_byte;
         if (bad_pos) begin
            cmd.status = STATUS_BAD_POS;
         end
      end else begin
         cmd.reg_select = req_item.req_type[0];
      end
   end

endmodule
`default_nettype wire

// File: sv/lcdws_queue.sv
// Two-entry command queue between the front end and the sequencer.
// Depends on lcdws_pkg.
`default_nettype none
module lcdws_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  lcdws_pkg::cmd_type wr_cmd,
   output logic               full,
   input  logic               rd_en,
   output logic               rd_valid,
   output lcdws_pkg::cmd_type rd_cmd
);
   import lcdws_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/lcdws_back.sv
// Back end: steps through the pin snapshots of one command into the result register.
// Depends on lcdws_pkg; keeps the port latch and strobe level.
`default_nettype none
module lcdws_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdws_pkg::csr_type      csr,
   input  logic                    cmd_valid,
   input  lcdws_pkg::cmd_type      cmd,
   output logic                    cmd_done,
   output logic                    empty,
   input  logic                    pop,
   output lcdws_pkg::rsp_item_type rsp_item
);
   import lcdws_pkg::*;

   logic [StepWidth-1:0] step_ff, step_in;
   logic [7:0]           latch_ff, latch_in;
   logic                 strobe_ff, strobe_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_ff, out_in;
   logic                 fire, rejected, last_step;
   logic [3:0]           nibble;
   logic [7:0]           half_latch;

   assign rejected  = cmd.status != STATUS_OK;
   assign last_step = csr.eight_bit_bus ? (step_ff == LAST_STEP_EIGHT)
                                        : (step_ff == LAST_STEP_FOUR);
   assign fire      = cmd_valid && (!out_valid_ff || pop);
   assign cmd_done  = fire && (rejected || last_step);

   assign nibble     = (step_ff == 3'd2) ? cmd.cmd_byte[7:4] : cmd.cmd_byte[3:0];
   assign half_latch = csr.upper_nibble_lane ? {nibble, latch_ff[3:0]}
                                             : {latch_ff[7:4], nibble};

   always_comb begin
      strobe_in = strobe_ff;
      latch_in  = latch_ff;
      if (!rejected) begin
         if (csr.eight_bit_bus) begin
            case (step_ff)
               3'd1:    strobe_in = 1'b1;
               3'd2:    latch_in  = cmd.cmd_byte;
               3'd3:    strobe_in = 1'b0;
               default: ;
            endcase
         end else begin
            case (step_ff)
               3'd1, 3'd4: strobe_in = 1'b1;
               3'd3, 3'd6: strobe_in = 1'b0;
               3'd2, 3'd5: latch_in  = half_latch;
               default:    ;
            endcase
         end
      end
   end

   always_comb begin
      out_in.reg_select   = rejected ? 1'b0 : cmd.reg_select;
      out_in.read_write   = 1'b0;
      out_in.enable_pin   = strobe_in;
      out_in.data_port    = latch_in;
      out_in.hold_time_us = (rejected || last_step) ? 16'd0 : csr.step_hold_us;
      out_in.status       = cmd.status;
      out_in.last         = rejected || last_step;
      out_valid_in        = fire || (out_valid_ff && !pop);
      step_in             = cmd_done ? '0 : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         latch_ff     <= 8'd0;
         strobe_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            step_ff   <= step_in;
            latch_ff  <= latch_in;
            strobe_ff <= strobe_in;
         end
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

endmodule
`default_nettype wire

// File: sv/lcdws_checker.sv
// Port-level checker for the character LCD write sequencer, bound to the top level.
// Depends on lcdws_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lcdws_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    push,
   input logic                    full,
   input lcdws_pkg::req_item_type req_item,
   input logic                    empty,
   input logic                    pop,
   input lcdws_pkg::rsp_item_type rsp_item,
   input logic                    csr_write_enable,
   input logic [1:0]              csr_index,
   input logic [15:0]             csr_wdata
);
   import lcdws_pkg::*;

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (empty && !full), "not empty after reset")
   `ASSERT_CLK(a_hold_result, clock, reset, (!empty && !pop) |=> !empty, "result dropped")
   `ASSERT_CLK(a_reject_last, clock, reset, (!empty && rsp_item.status != STATUS_OK) |-> (rsp_item.last && rsp_item.hold_time_us == 16'd0), "rejection not single")
   `ASSERT_CLK(a_final_low, clock, reset, (!empty && rsp_item.last && rsp_item.status == STATUS_OK) |-> (!rsp_item.enable_pin && rsp_item.hold_time_us == 16'd0), "final snapshot wrong")
   `ASSERT_CLK(a_write_only, clock, reset, !empty |-> !rsp_item.read_write, "read cycle driven")

endmodule

bind char_lcd_write_sequencer lcdws_checker u_lcdws_checker (.*);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for char_lcd_write_sequencer: a directed table, then random requests
// over several register settings; every pin snapshot is checked against an in-bench model.
// Depends on lcdws_pkg and the char_lcd_write_sequencer RTL.
module testbench;
   import lcdws_pkg::*;

   localparam logic [1:0] REQ_COMMAND    = 2'd0;
   localparam logic [1:0] REQ_CHARACTER  = 2'd1;
   localparam logic [1:0] REQ_CURSOR     = 2'd2;
   localparam logic [1:0] REQ_CURSOR_ALT = 2'd3;
   localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h10, 8'h50};
   localparam int QUIET_LIMIT     = 5000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_REQUESTS  = 52;
   localparam int REPORT_LINES    = 40;

   typedef enum logic {ROW_REQUEST, ROW_SETTING} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_item_type req;
      logic [1:0]   csr_idx;
      logic [15:0]  csr_val;
      bit           pinned;
      rsp_item_type pinned_rsp;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         full;
   req_item_type req_item = '0;
   logic         empty;
   logic         pop = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic [1:0]   csr_index = CSR_DISPLAY_READY;
   logic [15:0]  csr_wdata = '0;

   // model copy of the block's registers and pin state
   logic        cfg_ready;
   logic        cfg_eight;
   logic        cfg_upper;
   logic [15:0] cfg_hold;
   logic [7:0]  port_q;
   logic        strobe_q;

   rsp_item_type snapshot_q [$];
   plan_row_type directed_plan [$];
   rsp_item_type want;
   req_item_type next_req;

   int  mismatches = 0;
   int  snapshots_seen = 0;
   int  requests_sent = 0;
   int  settings_written = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  rsp_hold_request = 0;
   bit  sender_steady = 0;

   char_lcd_write_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_item         (req_item),
      .empty            (empty),
      .pop              (pop),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatches < REPORT_LINES) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   function automatic plan_row_type request_row(input logic [1:0] kind, input logic [7:0] code,
                                                input logic [3:0] row, input logic [4:0] col);
      plan_row_type p;
      p.kind = ROW_REQUEST;
      p.req = '{req_type: kind, data_byte: code, row: row, column: col};
      p.csr_idx = CSR_DISPLAY_READY;
      p.csr_val = '0;
      p.pinned = 0;
      p.pinned_rsp = '0;
      return p;
   endfunction

   function automatic plan_row_type reject_row(input logic [1:0] kind, input logic [7:0] code,
                                               input logic [3:0] row, input logic [4:0] col,
                                               input logic [1:0] st);
      plan_row_type p;
      p = request_row(kind, code, row, col);
      p.pinned = 1;
      p.pinned_rsp = '{reg_select: 1'b0, read_write: 1'b0, enable_pin: 1'b0,
                       data_port: 8'h00, hold_time_us: 16'h0000, status: st, last: 1'b1};
      return p;
   endfunction

   function automatic plan_row_type setting_row(input logic [1:0] idx, input logic [15:0] val);
      plan_row_type p;
      p = request_row(REQ_COMMAND, 8'h00, 4'd0, 5'd0);
      p.kind = ROW_SETTING;
      p.csr_idx = idx;
      p.csr_val = val;
      return p;
   endfunction

   function automatic void add_snapshot(input logic rs, input logic [15:0] hold,
                                        input logic [1:0] st, input logic fin);
      rsp_item_type s;
      s.reg_select = rs;
      s.read_write = 1'b0;
      s.enable_pin = strobe_q;
      s.data_port = port_q;
      s.hold_time_us = hold;
      s.status = st;
      s.last = fin;
      snapshot_q.push_back(s);
   endfunction

   function automatic void place_nibble(input logic [3:0] nib);
      if (cfg_upper) begin
         port_q[7:4] = nib;
      end else begin
         port_q[3:0] = nib;
      end
   endfunction

   function automatic void predict_pin_sequence(input req_item_type r);
      logic [7:0] code;
      logic       rs;
      if (!cfg_ready) begin
         add_snapshot(1'b0, 16'h0000, STATUS_NOT_READY, 1'b1);
         return;
      end
      if (r.req_type[1]) begin
         if (r.row > 4'd3 || r.column > 5'd15) begin
            add_snapshot(1'b0, 16'h0000, STATUS_BAD_POS, 1'b1);
            return;
         end
         code = CURSOR_CMD | (ROW_BASE[r.row[1:0]] + {3'b000, r.column});
         rs = 1'b0;
      end else begin
         code = r.data_byte;
         rs = r.req_type[0];
      end
      add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
      strobe_q = 1'b1;
      add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
      if (cfg_eight) begin
         port_q = code;
         add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
      end else begin
         place_nibble(code[7:4]);
         add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
         strobe_q = 1'b0;
         add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
         strobe_q = 1'b1;
         add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
         place_nibble(code[3:0]);
         add_snapshot(rs, cfg_hold, STATUS_OK, 1'b0);
      end
      strobe_q = 1'b0;
      add_snapshot(rs, 16'h0000, STATUS_OK, 1'b1);
   endfunction

   function automatic req_item_type random_request();
      req_item_type r;
      int unsigned  pick;
      pick = $urandom_range(99);
      r.req_type = (pick < 30) ? REQ_COMMAND : (pick < 55) ? REQ_CHARACTER :
                   (pick < 80) ? REQ_CURSOR : REQ_CURSOR_ALT;
      r.data_byte = 8'($urandom);
      if (r.req_type[1] && $urandom_range(99) < 80) begin
         r.row = 4'($urandom_range(3));
         r.column = 5'($urandom_range(15));
      end else begin
         r.row = 4'($urandom_range(15));
         r.column = 5'($urandom_range(31));
      end
      return r;
   endfunction

   task automatic send_request(input req_item_type r);
      while (!sender_steady && $urandom_range(99) < 25) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      requests_sent++;
   endtask

   // drop push and wait for every expected snapshot
   task automatic settle();
      push <= 1'b0;
      while (snapshot_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DISPLAY_READY: cfg_ready = val[0];
         CSR_EIGHT_BIT_BUS: cfg_eight = val[0];
         CSR_UPPER_LANE:    cfg_upper = val[0];
         CSR_STEP_HOLD:     cfg_hold = val;
         default:           ;
      endcase
      settings_written++;
      @(posedge clock);
   endtask

   // result side: random pop, one long hold-off on request, one stretch without gaps
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (snapshots_seen >= 600 && snapshots_seen < 900) begin
            pop <= 1'b1;
         end else begin
            pop <= ($urandom_range(99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (pop && !empty) begin
            if (snapshot_q.size() == 0) begin
               report_mismatch($sformatf("unexpected snapshot %p", rsp_item));
            end else begin
               want = snapshot_q.pop_front();
               if (rsp_item.reg_select !== want.reg_select)
                  report_mismatch($sformatf("snapshot %0d reg_select got %b want %b",
                     snapshots_seen, rsp_item.reg_select, want.reg_select));
               if (rsp_item.read_write !== want.read_write)
                  report_mismatch($sformatf("snapshot %0d read_write got %b want %b",
                     snapshots_seen, rsp_item.read_write, want.read_write));
               if (rsp_item.enable_pin !== want.enable_pin)
                  report_mismatch($sformatf("snapshot %0d enable_pin got %b want %b",
                     snapshots_seen, rsp_item.enable_pin, want.enable_pin));
               if (rsp_item.data_port !== want.data_port)
                  report_mismatch($sformatf("snapshot %0d data_port got %h want %h",
                     snapshots_seen, rsp_item.data_port, want.data_port));
               if (rsp_item.hold_time_us !== want.hold_time_us)
                  report_mismatch($sformatf("snapshot %0d hold_time_us got %0d want %0d",
                     snapshots_seen, rsp_item.hold_time_us, want.hold_time_us));
               if (rsp_item.status !== want.status)
                  report_mismatch($sformatf("snapshot %0d status got %0d want %0d",
                     snapshots_seen, rsp_item.status, want.status));
               if (rsp_item.last !== want.last)
                  report_mismatch($sformatf("snapshot %0d last got %b want %b",
                     snapshots_seen, rsp_item.last, want.last));
            end
            snapshots_seen++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles, %0d snapshots outstanding",
               QUIET_LIMIT, snapshot_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      cfg_ready = 1'b0;
      cfg_eight = 1'b0;
      cfg_upper = 1'b1;
      cfg_hold = HOLD_RESET;
      port_q = 8'h00;
      strobe_q = 1'b0;
      directed_plan = '{
         reject_row(REQ_COMMAND, 8'hFF, 4'd0, 5'd0, STATUS_NOT_READY),
         reject_row(REQ_CHARACTER, 8'h00, 4'd15, 5'd31, STATUS_NOT_READY),
         reject_row(REQ_CURSOR, 8'hA5, 4'd15, 5'd31, STATUS_NOT_READY),
         reject_row(REQ_CURSOR_ALT, 8'h5A, 4'd0, 5'd0, STATUS_NOT_READY),
         setting_row(CSR_DISPLAY_READY, 16'd1),
         reject_row(REQ_CURSOR, 8'h00, 4'd4, 5'd0, STATUS_BAD_POS),
         reject_row(REQ_CURSOR, 8'hFF, 4'd0, 5'd16, STATUS_BAD_POS),
         reject_row(REQ_CURSOR_ALT, 8'h00, 4'd15, 5'd31, STATUS_BAD_POS),
         request_row(REQ_COMMAND, 8'h00, 4'd0, 5'd0),
         request_row(REQ_CHARACTER, 8'hFF, 4'd15, 5'd31),
         request_row(REQ_CURSOR, 8'hA5, 4'd0, 5'd0),
         request_row(REQ_CURSOR_ALT, 8'h00, 4'd3, 5'd15),
         request_row(REQ_CURSOR, 8'h3C, 4'd1, 5'd7),
         request_row(REQ_CURSOR, 8'hC3, 4'd2, 5'd12),
         setting_row(CSR_EIGHT_BIT_BUS, 16'd1),
         setting_row(CSR_STEP_HOLD, 16'hFFFF),
         request_row(REQ_CHARACTER, 8'h00, 4'd0, 5'd0),
         request_row(REQ_COMMAND, 8'hFF, 4'd0, 5'd0),
         request_row(REQ_CURSOR_ALT, 8'hFF, 4'd3, 5'd15),
         setting_row(CSR_EIGHT_BIT_BUS, 16'd0),
         setting_row(CSR_UPPER_LANE, 16'd0),
         setting_row(CSR_STEP_HOLD, 16'h0000),
         request_row(REQ_CHARACTER, 8'h5A, 4'd0, 5'd0),
         request_row(REQ_COMMAND, 8'hC3, 4'd0, 5'd0),
         setting_row(CSR_DISPLAY_READY, 16'd0),
         request_row(REQ_CHARACTER, 8'h77, 4'd0, 5'd0),
         request_row(REQ_CURSOR, 8'h11, 4'd9, 5'd20)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_SETTING) begin
            settle();
            write_csr(directed_plan[i].csr_idx, directed_plan[i].csr_val);
         end else begin
            send_request(directed_plan[i].req);
            if (directed_plan[i].pinned) begin
               snapshot_q.push_back(directed_plan[i].pinned_rsp);
            end else begin
               predict_pin_sequence(directed_plan[i].req);
            end
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         write_csr(CSR_DISPLAY_READY, (phase == 4) ? 16'd0 : 16'd1);
         write_csr(CSR_EIGHT_BIT_BUS, (phase == 0) ? 16'd0 : (phase == 1) ? 16'd1 :
                                      16'($urandom_range(1)));
         write_csr(CSR_UPPER_LANE, (phase == 0) ? 16'd0 : (phase == 2) ? 16'd1 :
                                   16'($urandom_range(1)));
         write_csr(CSR_STEP_HOLD, (phase == 1) ? 16'hFFFF : (phase == 2) ? 16'h0000 :
                                  16'($urandom_range(65535)));
         sender_steady = (phase == 3);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (phase == 1 && n == 26) settle();
            if (phase == 2 && n == 10) rsp_hold_request = 1;
            next_req = random_request();
            send_request(next_req);
            predict_pin_sequence(next_req);
         end
      end

      settle();
      repeat (12) @(posedge clock);
      $display("%0d requests sent, %0d pin snapshots checked, %0d register writes",
         requests_sent, snapshots_seen, settings_written);
      $display("covered rejections, cursor moves, both bus widths and lanes, hold extremes");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
